FILE: design/dscp_pkg.sv
// Shared constants and types for the parabolic degree sine/cosine unit.
package dscp_pkg;

   // default fraction bits of the result
   localparam int FRAC_BITS_DEF = 14;

   // field widths
   localparam int ANGLE_W = 32;
   localparam int SUM_W   = ANGLE_W + 2;
   localparam int MAG_W   = 32;
   localparam int VALUE_W = 16;
   localparam int RES_W   = 32;

   // function select codes
   localparam logic FUNC_SINE   = 1'b0;
   localparam logic FUNC_COSINE = 1'b1;

   // angle constants in degrees
   localparam int DEG_QUARTER = 90;
   localparam int DEG_HALF    = 180;
   localparam int DEG_TURN    = 360;

   // reduction mod 360 by reciprocal multiply
   localparam int          RECIP_SHIFT = 40;
   localparam logic [31:0] RECIP_TURN  = 32'((64'd1 << RECIP_SHIFT) / DEG_TURN);
   localparam int          QUOT_W      = 24;
   localparam int          REM_W       = 10;
   localparam int          DEG_W       = 9;
   localparam int          FOLD_W      = 7;

   // parabola d*(180-d)/8100 with round to nearest
   localparam longint PARA_DIV  = DEG_QUARTER * DEG_QUARTER;
   localparam longint PARA_HALF = PARA_DIV / 2;

   // correction weight 0.225 = 3686 / 2^14
   localparam int CORR_NUM   = 3686;
   localparam int CORR_SHIFT = 14;

   // queue depths
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 16;

   // item handed from the front part to the back part
   typedef struct packed {
      logic             neg;
      logic [SUM_W-1:0] angle;
   } turn_item_type;

endpackage

FILE: design/dscp_fifo.sv
// Small register-based first-in first-out queue.
module dscp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/dscp_front.sv
// Front part: applies the cosine offset and classifies the angle sign.
module dscp_front import dscp_pkg::*; (
   input  logic                      req_func,
   input  logic signed [ANGLE_W-1:0] req_angle_deg,
   output turn_item_type             item
);

   logic [SUM_W-1:0] angle_ext;
   logic [SUM_W-1:0] offset;
   logic [SUM_W-1:0] sum;

   // cosine is sine shifted by a quarter turn, in wider arithmetic
   always_comb begin
      angle_ext  = {{(SUM_W - ANGLE_W){req_angle_deg[ANGLE_W-1]}}, req_angle_deg};
      offset     = (req_func == FUNC_COSINE) ? SUM_W'(DEG_QUARTER) : '0;
      sum        = angle_ext + offset;
      item.neg   = sum[SUM_W-1];
      item.angle = sum;
   end

endmodule

FILE: design/dscp_back.sv
// Back part: turn reduction, folding, parabola lookup, correction and sign.
module dscp_back import dscp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      extra_precision,
   input  logic                      mid_empty,
   input  turn_item_type             mid_item,
   output logic                      mid_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output logic signed [VALUE_W-1:0] rsp_value
);

   localparam int YW    = FRAC_BITS + 1;
   localparam int SQ_W  = 2 * YW + 1;
   localparam int CP_W  = YW + CORR_SHIFT + 1;
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int NSTG  = 7;

   // issue control
   logic [CNT_W-1:0] outst_ff, outst_in;
   logic             issue;
   logic             popped;
   logic [NSTG:1]    vld_ff, vld_in;

   // stage registers
   logic             neg1_ff, neg2_ff, neg3_ff;
   logic [MAG_W-1:0] mag1_ff, mag2_ff, mag3_ff;
   logic [MAG_W-1:0] mag1_in;
   logic [2*MAG_W-1:0] prod2_ff, prod2_in;
   logic [MAG_W-1:0] qm3_ff, qm3_in;
   logic [FOLD_W-1:0] d4_ff, d4_in;
   logic             half4_ff, half4_in;
   logic [YW-1:0]    y5_ff, y6_ff, y7_ff;
   logic             half5_ff, half6_ff, half7_ff;
   logic [YW-1:0]    sq6_ff, sq6_in;
   logic [YW-1:0]    corr7_ff, corr7_in;

   // combinational helpers
   logic [SUM_W-1:0]  neg_angle;
   logic [QUOT_W-1:0] quot;
   logic [MAG_W-1:0]  quot_ext;
   logic [MAG_W-1:0]  diff;
   logic [REM_W-1:0]  rem;
   logic [DEG_W-1:0]  r0;
   logic [DEG_W-1:0]  r_turn;
   logic [DEG_W-1:0]  r_half;
   logic [DEG_W-1:0]  r_fold;
   logic [YW-1:0]     ptab [2**FOLD_W];
   logic [SQ_W-1:0]   sq_full;
   logic [YW-1:0]     m7;
   logic [CP_W-1:0]   cprod;
   logic [YW-1:0]     y_fix;
   logic [RES_W-1:0]  res;
   logic [VALUE_W-1:0] value;
   logic              out_full;
   logic [VALUE_W-1:0] out_data;

   // credit: items in flight plus items waiting never exceed the output queue
   assign issue   = !mid_empty && (outst_ff < CNT_W'(OUT_DEPTH));
   assign mid_pop = issue;
   assign popped  = rsp_pop && !rsp_empty;
   assign outst_in = outst_ff + CNT_W'(issue) - CNT_W'(popped);
   assign vld_in   = {vld_ff[NSTG-1:1], issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
         vld_ff   <= '0;
      end else begin
         outst_ff <= outst_in;
         vld_ff   <= vld_in;
      end
   end

   // stage 1: magnitude of the angle
   always_comb begin
      neg_angle = -mid_item.angle;
      mag1_in   = mid_item.neg ? neg_angle[MAG_W-1:0] : mid_item.angle[MAG_W-1:0];
   end

   // stage 2: quotient estimate by reciprocal
   assign prod2_in = 64'(mag1_ff) * 64'(RECIP_TURN);

   // stage 3: quotient times a turn
   always_comb begin
      quot     = prod2_ff[RECIP_SHIFT +: QUOT_W];
      quot_ext = MAG_W'(quot);
      qm3_in   = quot_ext * MAG_W'(DEG_TURN);
   end

   // stage 4: remainder with one correction, then fold to a quarter turn
   always_comb begin
      diff   = mag3_ff - qm3_ff;
      rem    = diff[REM_W-1:0];
      r0     = (rem >= REM_W'(DEG_TURN)) ? DEG_W'(rem - REM_W'(DEG_TURN)) : DEG_W'(rem);
      if (neg3_ff) begin
         r_turn = (r0 == '0) ? DEG_W'(DEG_TURN) : DEG_W'(DEG_TURN) - r0;
      end else begin
         r_turn = r0;
      end
      half4_in = (r_turn >= DEG_W'(DEG_HALF));
      r_half   = half4_in ? r_turn - DEG_W'(DEG_HALF) : r_turn;
      r_fold   = (r_half > DEG_W'(DEG_QUARTER)) ? DEG_W'(DEG_HALF) - r_half : r_half;
      d4_in    = r_fold[FOLD_W-1:0];
   end

   // parabola table, one entry per folded degree
   for (genvar gi = 0; gi < 2**FOLD_W; gi++) begin : g_ptab
      localparam longint PROD  = (gi <= DEG_QUARTER) ? longint'(gi * (DEG_HALF - gi)) : 0;
      localparam longint ENTRY = ((PROD << FRAC_BITS) + PARA_HALF) / PARA_DIV;
      assign ptab[gi] = YW'(ENTRY);
   end

   // stage 6: rounded square
   always_comb begin
      sq_full = SQ_W'(y5_ff) * SQ_W'(y5_ff) + (SQ_W'(1) << (FRAC_BITS - 1));
      sq6_in  = YW'(sq_full >> FRAC_BITS);
   end

   // stage 7: weighted correction term
   always_comb begin
      m7       = (sq6_ff <= y6_ff) ? y6_ff - sq6_ff : '0;
      cprod    = CP_W'(m7) * CP_W'(CORR_NUM) + (CP_W'(1) << (CORR_SHIFT - 1));
      corr7_in = YW'(cprod >> CORR_SHIFT);
   end

   // final: apply correction and sign
   always_comb begin
      if (extra_precision) begin
         y_fix = (corr7_ff <= y7_ff) ? y7_ff - corr7_ff : '0;
      end else begin
         y_fix = y7_ff;
      end
      res   = half7_ff ? -RES_W'(y_fix) : RES_W'(y_fix);
      value = res[VALUE_W-1:0];
   end

   // pipeline payload, no reset
   always_ff @(posedge clock) begin
      neg1_ff  <= mid_item.neg;
      mag1_ff  <= mag1_in;
      neg2_ff  <= neg1_ff;
      mag2_ff  <= mag1_ff;
      prod2_ff <= prod2_in;
      neg3_ff  <= neg2_ff;
      mag3_ff  <= mag2_ff;
      qm3_ff   <= qm3_in;
      d4_ff    <= d4_in;
      half4_ff <= half4_in;
      y5_ff    <= ptab[d4_ff];
      half5_ff <= half4_ff;
      y6_ff    <= y5_ff;
      sq6_ff   <= sq6_in;
      half6_ff <= half5_ff;
      y7_ff    <= y6_ff;
      corr7_ff <= corr7_in;
      half7_ff <= half6_ff;
   end

   // result queue
   dscp_fifo #(
      .WIDTH (VALUE_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (vld_ff[NSTG]),
      .push_data (value),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .empty     (rsp_empty)
   );

   assign rsp_value = $signed(out_data);

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG] |-> !out_full)
      else $error("result reached a full output queue");

   a_idle_when_no_credit: assert property (@(posedge clock) disable iff (reset)
      (outst_ff == '0) |-> (vld_ff == '0 && rsp_empty))
      else $error("item in flight with no outstanding count");

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (d4_ff <= FOLD_W'(DEG_QUARTER)))
      else $error("folded angle above a quarter turn");

   a_parabola_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (y5_ff <= (YW'(1) << FRAC_BITS)))
      else $error("parabola magnitude above one");
`endif

endmodule

FILE: design/degree_sine_cosine_parabolic.sv
// Top level of the parabolic degree sine/cosine unit.
//
//   channel  ports                                   direction  handshake
//   req      req_push req_full req_func req_angle_deg  in        push & !full
//   rsp      rsp_pop rsp_empty rsp_value               out       pop & !empty
//   csr      csr_valid csr_ready csr_data              in        valid & ready
//
// One item is accepted per cycle while req_full is low. Each item passes through the
// seven-stage back pipeline (magnitude, two multiplies for the mod 360 reduction,
// fold, table lookup, square, weight multiply) and its result is then written into
// the result queue; items reach the back pipeline through the mid queue.
// Synchronous active-high reset clears queues, credits and extra_precision.
// A stalled rsp side fills the 16-entry result queue, then the 4-entry mid
// queue, then req_full rises; the input side never blocks the output side.
module degree_sine_cosine_parabolic import dscp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_func,
   input  logic signed [ANGLE_W-1:0] req_angle_deg,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [VALUE_W-1:0] rsp_value,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);

   localparam int ITEM_W = $bits(turn_item_type);

   logic              extra_precision_ff, extra_precision_in;
   turn_item_type     front_item;
   turn_item_type     mid_item;
   logic [ITEM_W-1:0] mid_bits;
   logic              mid_empty;
   logic              mid_pop;

   // configuration register
   assign csr_ready          = 1'b1;
   assign extra_precision_in = csr_valid ? csr_data : extra_precision_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         extra_precision_ff <= 1'b0;
      end else begin
         extra_precision_ff <= extra_precision_in;
      end
   end

   // classify incoming items
   dscp_front u_front (
      .req_func      (req_func),
      .req_angle_deg (req_angle_deg),
      .item          (front_item)
   );

   // queue between front and back
   dscp_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (mid_pop),
      .pop_data  (mid_bits),
      .empty     (mid_empty)
   );

   assign mid_item = turn_item_type'(mid_bits);

   // evaluation pipeline and result queue
   dscp_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .extra_precision (extra_precision_ff),
      .mid_empty       (mid_empty),
      .mid_item        (mid_item),
      .mid_pop         (mid_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_value       (rsp_value)
   );

endmodule

FILE: tb/tb_trig_pkg.sv
// Predictor and scoreboard for the parabolic degree sine/cosine unit.
`timescale 1ns / 1ps
package tb_trig_pkg;
   import dscp_pkg::*;

   // independent copies of the arithmetic constants
   localparam longint unsigned QUAD_SQ     = 8100;
   localparam longint unsigned QUAD_SQ_RND = 4050;
   localparam longint unsigned WEIGHT_NUM  = 3686;
   localparam int              WEIGHT_SH   = 14;
   localparam int              Q_FRAC      = 14;

   // one expected result together with the item that caused it
   typedef struct {
      logic               func;
      logic [ANGLE_W-1:0] angle;
      logic [VALUE_W-1:0] value;
   } trig_expect_type;

   // sine/cosine of a whole-degree angle as a rounded Q2.14 parabola
   function automatic logic [VALUE_W-1:0] parabolic_trig(logic func,
         logic [ANGLE_W-1:0] angle, bit precise);
      longint deg;
      longint fold;
      longint unsigned mag, num, sq, diff, corr;
      logic [VALUE_W-1:0] res;
      bit lower_half;
      deg = longint'(signed'(angle));
      if (func == FUNC_COSINE)
         deg = deg + 90;
      // reduce into one turn; negative multiples of a turn land on 360
      if (deg < 0)
         fold = 360 - ((-deg) % 360);
      else
         fold = deg % 360;
      lower_half = (fold >= 180);
      if (lower_half)
         fold = fold - 180;
      if (fold > 90)
         fold = 180 - fold;
      num = longint'(fold * (180 - fold)) << Q_FRAC;
      mag = (num + QUAD_SQ_RND) / QUAD_SQ;
      // optional correction on the magnitude
      if (precise) begin
         sq   = (mag * mag + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
         diff = (sq <= mag) ? mag - sq : 0;
         corr = (diff * WEIGHT_NUM + (64'd1 << (WEIGHT_SH - 1))) >> WEIGHT_SH;
         mag  = (corr <= mag) ? mag - corr : 0;
      end
      res = mag[VALUE_W-1:0];
      if (lower_half)
         res = -res;
      return res;
   endfunction

   class trig_scoreboard;
      trig_expect_type pending_values[$];
      bit              precise;
      int              mismatches;

      // predict the result of an accepted item
      function void note_angle(logic func, logic [ANGLE_W-1:0] angle);
         trig_expect_type e;
         e.func  = func;
         e.angle = angle;
         e.value = parabolic_trig(func, angle, precise);
         pending_values.push_back(e);
      endfunction

      // compare an accepted result with the oldest prediction
      function void check_value(logic [VALUE_W-1:0] actual);
         trig_expect_type e;
         if (pending_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result %0d", $time, $signed(actual));
            return;
         end
         e = pending_values.pop_front();
         if (actual !== e.value) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: func %0b angle %0d precise %0b: expected %0d, got %0d",
                        $time, e.func, $signed(e.angle), precise,
                        $signed(e.value), $signed(actual));
         end
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench of the parabolic degree sine/cosine unit.
`timescale 1ns / 1ps
module tb_top;
   import dscp_pkg::*;
   import tb_trig_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 240;
   localparam int HOLD_AFTER  = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_func = FUNC_SINE;
   logic [ANGLE_W-1:0] req_angle_deg = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [VALUE_W-1:0] rsp_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_data = 1'b0;

   trig_scoreboard sb;
   int  cycle_count = 0;
   int  items_sent = 0;
   bit  tx_steady = 1'b0;
   bit  rx_hold = 1'b0;

   degree_sine_cosine_parabolic uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_angle_deg (req_angle_deg),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_value     (rsp_value),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // offer one item; push stays high if the next item follows at once
   task automatic send_item(logic func, logic [ANGLE_W-1:0] angle);
      int gap;
      gap = (tx_steady || rx_hold) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_func      <= func;
      req_angle_deg <= angle;
      do @(posedge clock); while (req_full !== 1'b0);
      sb.note_angle(func, angle);
      items_sent++;
   endtask

   // write extra_precision; only called while the unit is idle
   task automatic write_precision(bit val);
      csr_valid <= 1'b1;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.precise = val;
      csr_valid <= 1'b0;
   endtask

   // wait until every predicted result has come back, then let the pipe settle
   task automatic drain;
      while (sb.pending_values.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // mixed angle picks: full range, small, near turn multiples, extremes, fold edges
   function automatic logic [ANGLE_W-1:0] draw_angle();
      longint v;
      case ($urandom_range(0, 5))
         0: v = longint'($urandom);
         1: v = longint'($urandom_range(0, 720)) - 360;
         2: v = -longint'($urandom_range(0, 2000));
         3: v = (longint'($urandom_range(0, 11930464)) - 5965232) * 360
                + longint'($urandom_range(0, 4)) - 2;
         4: begin
            case ($urandom_range(0, 5))
               0: v = longint'(32'h7fff_ffff);
               1: v = -2147483648;
               2: v = 2147483647 - longint'($urandom_range(0, 120));
               3: v = -2147483648 + longint'($urandom_range(0, 120));
               4: v = 0;
               default: v = -1;
            endcase
         end
         default: begin
            v = 90 * longint'($urandom_range(0, 8)) + longint'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1))
               v = -v;
         end
      endcase
      return v[ANGLE_W-1:0];
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0)
            tx_steady = ($urandom_range(0, 3) == 0);
         send_item(1'($urandom_range(0, 1)), draw_angle());
      end
      tx_steady = 1'b0;
      req_push <= 1'b0;
   endtask

   // directed angles, each as sine and as cosine
   task automatic run_directed;
      int angles[12];
      angles = '{0, 90, 180, 270, 360, -360, -90, 45, 135, -1,
                 int'(32'h7fff_ffff), int'(32'h8000_0000)};
      foreach (angles[k]) begin
         send_item(FUNC_SINE, angles[k]);
         send_item(FUNC_COSINE, angles[k]);
      end
      req_push <= 1'b0;
   endtask

   // result side
   initial begin
      int  gap;
      int  n;
      bit  rx_steady;
      n = 0;
      rx_steady = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (n % 64 == 0)
            rx_steady = ($urandom_range(0, 3) == 0);
         gap = rx_steady ? 0 : $urandom_range(0, 17);
         if (gap > 0 || rx_hold) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
            while (rx_hold) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         sb.check_value(rsp_value);
         n++;
      end
   end

   // long receiver hold-off so the unit fills up and raises req_full
   initial begin
      wait (items_sent >= HOLD_AFTER);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // main sequence
   initial begin
      sb = new;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_precision(1'b0);
      run_directed();
      drain();

      write_precision(1'b1);
      run_random(440);
      drain();

      write_precision(1'b0);
      run_random(440);
      drain();

      write_precision(1'b1);
      run_random(440);
      drain();

      write_precision(1'b0);
      run_random(430);
      drain();

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_values.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
